@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EDP_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define EDP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/edp_pkg.sv @@
`default_nettype none
package edp_pkg;

    localparam int AGE_W   = 3;
    localparam int VAL_W   = 16;
    localparam int LIFE_W  = 4;
    localparam int HOR_W   = 6;
    localparam int COST_W  = 32;
    localparam int STAGE_W = 6;
    localparam int MASK_W  = 8;

    // register indexes on the configuration port
    localparam logic [1:0] REG_PURCHASE = 2'd0;
    localparam logic [1:0] REG_LIFE     = 2'd1;
    localparam logic [1:0] REG_HORIZON  = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0]  purchase_cost;
        logic [LIFE_W-1:0] life_years;
        logic [HOR_W-1:0]  horizon;
    } cfg_t;

    typedef struct packed {
        logic [STAGE_W-1:0]       stage;
        logic signed [COST_W-1:0] min_cost;
        logic signed [COST_W-1:0] gain;
        logic [MASK_W-1:0]        choice_mask;
        logic                     is_terminal;
        logic                     last;
    } out_rec_t;

endpackage
`default_nettype wire

@@ rtl/core/edp_ram.sv @@
`default_nettype none
module edp_ram #(
    parameter int W  = 32,
    parameter int D  = 8,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/edp_seq.sv @@
`default_nettype none
module edp_seq import edp_pkg::*; #(
    parameter int MAX_LIFE    = 8,
    parameter int MAX_HORIZON = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_func,
    input  wire logic [AGE_W-1:0] in_age,
    input  wire logic [VAL_W-1:0] in_resale,
    input  wire logic [VAL_W-1:0] in_maint,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_rec_t              out_rec
);

    localparam int LW  = (MAX_LIFE > 1) ? $clog2(MAX_LIFE) : 1;
    localparam int LCW = $clog2(MAX_LIFE + 1);
    localparam int HW  = $clog2(MAX_HORIZON + 1);
    localparam int CW  = HOR_W + 1;
    localparam int IXW = ((LW > AGE_W) ? LW : AGE_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CC_RD, ST_CC_WR, ST_TERM, ST_SCAN, ST_FIN, ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic [HW-1:0]             s_reg;
    logic [LCW-1:0]            k_reg;
    logic signed [COST_W-1:0]  acc_reg;
    logic                      rd_vld_reg;
    logic [LCW-1:0]            rd_k_reg;
    logic signed [COST_W-1:0]  best_reg;
    logic [MASK_W-1:0]         mask_reg;
    logic                      out_valid_reg;
    out_rec_t                  out_rec_reg;

    logic [CW-1:0]             life_ext, hor_ext;
    logic [LCW-1:0]            life_sat;
    logic [HW-1:0]             hor_sat, rem;
    logic                      last_k, out_free, out_load, age_ok;
    logic [IXW-1:0]            age_ext;

    logic                      tbl_we;
    logic [2*VAL_W-1:0]        tbl_rdata;
    logic [LW-1:0]             tbl_waddr;
    logic                      cc_we;
    logic [LW-1:0]             cc_raddr;
    logic signed [COST_W-1:0]  cc_wdata, cc_rdata;
    logic                      sv_we;
    logic [HW-1:0]             sv_waddr, sv_raddr;
    logic signed [COST_W-1:0]  sv_wdata, sv_rdata;

    logic signed [COST_W-1:0]  acc_next, cand, best_next;
    logic [MASK_W-1:0]         mask_next, k_bit;
    logic signed [COST_W-1:0]  purchase_s;

    assign life_ext = CW'(cfg.life_years);
    assign hor_ext  = CW'(cfg.horizon);
    assign life_sat = (life_ext == '0) ? LCW'(1) :
                      (life_ext > CW'(MAX_LIFE)) ? LCW'(MAX_LIFE) : life_ext[LCW-1:0];
    assign hor_sat  = (hor_ext > CW'(MAX_HORIZON)) ? HW'(MAX_HORIZON) : hor_ext[HW-1:0];
    assign rem      = hor_sat - s_reg;
    // last feasible keep length: stop at the useful life or at the horizon
    assign last_k   = (CW'(k_reg) == CW'(life_sat)) || (CW'(k_reg) == CW'(rem));
    assign out_free = !out_valid_reg || out_ready;
    // load the output register with a stage result
    assign out_load = ((state_reg == ST_TERM) || (state_reg == ST_EMIT)) && out_free;

    assign age_ext   = IXW'(in_age);
    assign age_ok    = age_ext < IXW'(MAX_LIFE);
    assign tbl_waddr = age_ext[LW-1:0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign tbl_we    = in_valid && in_ready && (in_func == FUNC_LOAD) && age_ok;

    assign purchase_s = COST_W'(cfg.purchase_cost);
    assign acc_next   = acc_reg + COST_W'(tbl_rdata[2*VAL_W-1:VAL_W]);
    assign cc_wdata   = purchase_s + acc_next - COST_W'(tbl_rdata[VAL_W-1:0]);
    assign cc_we      = (state_reg == ST_CC_WR);
    assign cc_raddr   = LW'(k_reg - LCW'(1));
    assign sv_raddr   = HW'(CW'(s_reg) + CW'(k_reg));

    always_comb begin
        sv_we    = 1'b0;
        sv_waddr = s_reg;
        sv_wdata = best_reg;
        if (state_reg == ST_TERM) begin
            sv_we    = 1'b1;
            sv_waddr = hor_sat;
            sv_wdata = '0;
        end else if (state_reg == ST_EMIT) begin
            sv_we = 1'b1;
        end
    end

    // fold one option into the running minimum and tie mask
    always_comb begin
        cand  = cc_rdata + sv_rdata;
        k_bit = '0;
        if (CW'(rd_k_reg) <= CW'(MASK_W)) begin
            k_bit = MASK_W'(1) << (rd_k_reg - LCW'(1));
        end
        best_next = best_reg;
        mask_next = mask_reg;
        if ((rd_k_reg == LCW'(1)) || (cand < best_reg)) begin
            best_next = cand;
            mask_next = k_bit;
        end else if (cand == best_reg) begin
            mask_next = mask_reg | k_bit;
        end
    end

    edp_ram #(.W(2*VAL_W), .D(MAX_LIFE)) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata ({in_maint, in_resale}),
        .raddr (k_reg[LW-1:0]),
        .rdata (tbl_rdata)
    );

    edp_ram #(.W(COST_W), .D(MAX_LIFE)) u_cc (
        .aclk  (aclk),
        .we    (cc_we),
        .waddr (k_reg[LW-1:0]),
        .wdata (cc_wdata),
        .raddr (cc_raddr),
        .rdata (cc_rdata)
    );

    edp_ram #(.W(COST_W), .D(MAX_HORIZON + 1)) u_sv (
        .aclk  (aclk),
        .we    (sv_we),
        .waddr (sv_waddr),
        .wdata (sv_wdata),
        .raddr (sv_raddr),
        .rdata (sv_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= (state_reg == ST_SCAN);
            rd_k_reg   <= k_reg;
            if (rd_vld_reg) begin
                best_reg <= best_next;
                mask_reg <= mask_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid && (in_func == FUNC_RUN)) begin
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_CC_RD;
                    end
                end
                ST_CC_RD: begin
                    state_reg <= ST_CC_WR;
                end
                ST_CC_WR: begin
                    acc_reg <= acc_next;
                    if (k_reg == life_sat - LCW'(1)) begin
                        state_reg <= ST_TERM;
                    end else begin
                        k_reg     <= k_reg + LCW'(1);
                        state_reg <= ST_CC_RD;
                    end
                end
                ST_TERM: begin
                    if (out_free) begin
                        out_rec_reg.stage       <= STAGE_W'(hor_sat);
                        out_rec_reg.min_cost    <= '0;
                        out_rec_reg.gain        <= purchase_s;
                        out_rec_reg.choice_mask <= '0;
                        out_rec_reg.is_terminal <= 1'b1;
                        out_rec_reg.last        <= (hor_sat == '0);
                        if (hor_sat == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            s_reg     <= hor_sat - HW'(1);
                            k_reg     <= LCW'(1);
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (last_k) begin
                        state_reg <= ST_FIN;
                    end else begin
                        k_reg <= k_reg + LCW'(1);
                    end
                end
                ST_FIN: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_rec_reg.stage       <= STAGE_W'(s_reg);
                        out_rec_reg.min_cost    <= best_reg;
                        out_rec_reg.gain        <= purchase_s - best_reg;
                        out_rec_reg.choice_mask <= mask_reg;
                        out_rec_reg.is_terminal <= 1'b0;
                        out_rec_reg.last        <= (s_reg == '0);
                        if (s_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            s_reg     <= s_reg - HW'(1);
                            k_reg     <= LCW'(1);
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule
`default_nettype wire

@@ rtl/core/equipment_replacement_dp_core.sv @@
// Equipment replacement dynamic program.
// Input stream (s_*): one item per handshake. s_tuser = 0 loads one age row
// (resale value and maintenance cost) and returns nothing.
// s_tuser = 1 starts a run: the block first builds the keep-length costs,
// then walks the stages from the horizon down to zero and emits one item per
// stage on m_*, the stage-zero item carrying m_tlast.
// Run: the block first builds the keep-length cost table, then for each
// non-terminal stage scans min(L, horizon - stage) keep lengths; one option
// is folded per cycle through the stage-value and cycle-cost memory read
// ports (L = saturated life). s_tready is low during a run.
// Results leave through one output register; if m_tready is low the sequencer
// holds at the next result until the register frees, and the next run's
// item can be taken while the final result of a run still waits.
// Reset clears the sequencer and output valid and sets the registers to
// purchase_cost 0, life_years 3, horizon 5. The age rows hold no reset value.
// Config registers (APB, byte address 4*i): purchase_cost, life_years, horizon.
`default_nettype none
module equipment_replacement_dp_core import edp_pkg::*; #(
    parameter int MAX_LIFE    = 8,
    parameter int MAX_HORIZON = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // age_index[2:0], resale_value[18:3], maint_cost[34:19]
    input  wire logic        s_tuser,  // func
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [79:0] m_tdata,  // stage[5:0], min_cost[37:6], gain[69:38],
                                       // choice_mask[77:70]
    output logic             m_tuser,  // is_terminal
    output logic             m_tlast   // last
);

    cfg_t     cfg_reg;
    out_rec_t rec;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register write: unknown indexes fall through and are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.purchase_cost <= '0;
            cfg_reg.life_years    <= LIFE_W'(3);
            cfg_reg.horizon       <= HOR_W'(5);
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_PURCHASE: cfg_reg.purchase_cost <= pwdata[VAL_W-1:0];
                REG_LIFE:     cfg_reg.life_years    <= pwdata[LIFE_W-1:0];
                REG_HORIZON:  cfg_reg.horizon       <= pwdata[HOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PURCHASE: prdata = 32'(cfg_reg.purchase_cost);
            REG_LIFE:     prdata = 32'(cfg_reg.life_years);
            REG_HORIZON:  prdata = 32'(cfg_reg.horizon);
            default:      prdata = '0;
        endcase
    end

    edp_seq #(.MAX_LIFE(MAX_LIFE), .MAX_HORIZON(MAX_HORIZON)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_age    (s_tdata[2:0]),
        .in_resale (s_tdata[18:3]),
        .in_maint  (s_tdata[34:19]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (rec)
    );

    // pack result fields, lowest field first, padded to whole bytes
    assign m_tdata = {2'b00, rec.choice_mask, rec.gain, rec.min_cost, rec.stage};
    assign m_tuser = rec.is_terminal;
    assign m_tlast = rec.last;

endmodule
`default_nettype wire

@@ rtl/core/edp_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module edp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // a stalled result item holds
    `EDP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // the closing item of a run is stage zero
    `EDP_ASSERT_SAME(a_last_stage0, aclk, aresetn, m_tvalid && m_tlast, m_tdata[5:0] == 6'd0)

    // more results pending means the run is still busy and takes no item
    `EDP_ASSERT_SAME(a_busy_no_in, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

    // the horizon stage has zero cost and no choice
    `EDP_ASSERT_SAME(a_term_zero, aclk, aresetn, m_tvalid && m_tuser, (m_tdata[37:6] == 32'd0) && (m_tdata[77:70] == 8'd0))

endmodule

bind equipment_replacement_dp_core edp_checker u_edp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
